// File: sv/md5_pkg.sv
package md5_pkg;

  // Standard initial chaining value, word 0 in the lowest bits
  localparam logic [3:0][31:0] MD5_IV = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] MD5_PAD_MARK = 8'h80;
  localparam logic [5:0] MD5_LEN_POS  = 6'd56;

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, round mod 4}
  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Control from the byte packer to the compression unit
  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    logic       start;
    logic       restart;
  } md5_ctl_t;

  // Message word used by a round
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    md5_g = lo;
      2'd1:    md5_g = 4'(lo * 4'd5 + 4'd1);
      2'd2:    md5_g = 4'(lo * 4'd3 + 4'd5);
      2'd3:    md5_g = 4'(lo * 4'd7);
      default: md5_g = lo;
    endcase
  endfunction

endpackage

// File: sv/md5_cmp.sv
module md5_cmp
  import md5_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  md5_ctl_t         ctl,
  input  logic [31:0]      wr_data,
  output logic             done,
  output logic [3:0][31:0] cv
);

  localparam logic [1:0] C_IDLE  = 2'd0;
  localparam logic [1:0] C_LOAD  = 2'd1;
  localparam logic [1:0] C_ROUND = 2'd2;
  localparam logic [1:0] C_ADD   = 2'd3;

  logic [1:0]  state;
  logic [5:0]  r;
  logic [31:0] a, b, c, d;
  logic [31:0] mword, kword;
  logic [31:0] mem [16];

  logic [5:0]  rd_round;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  // Fetch one round ahead: the read port is registered
  assign rd_round = (state == C_LOAD) ? r : 6'(r + 6'd1);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    mword <= mem[md5_g(rd_round)];
    kword <= MD5_K[rd_round];
  end

  always_comb begin
    case (r[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    s   = MD5_S[{r[5:4], r[1:0]}];
    sum = a + f + kword + mword;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        a <= cv[0];
        b <= cv[1];
        c <= cv[2];
        d <= cv[3];
      end
      C_ROUND: begin
        a <= d;
        d <= c;
        c <= b;
        b <= b + rot;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      r     <= '0;
      done  <= 1'b0;
      cv    <= MD5_IV;
    end else begin
      done <= 1'b0;
      case (state)
        C_IDLE: begin
          r <= '0;
          if (ctl.restart) begin
            cv <= MD5_IV;
          end else if (ctl.start) begin
            state <= C_LOAD;
          end
        end
        C_LOAD: state <= C_ROUND;
        C_ROUND: begin
          r <= 6'(r + 6'd1);
          if (r == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          cv[0] <= cv[0] + a;
          cv[1] <= cv[1] + b;
          cv[2] <= cv[2] + c;
          cv[3] <= cv[3] + d;
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: sv/md5_message_digest.sv
// Message bytes are taken one per cycle while a block fills; a full block then passes through
// start, one operand fetch, 64 rounds on the shared round unit and a final add, during which
// no request is taken. A last request adds the padding bytes plus one or two blocks,
// then four result words, one per cycle while the sink is ready.
// Reset (rst, synchronous, active high) restores the initial chaining value and clears
// the byte count and block fill.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast    // last_word
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // take requests
  localparam logic [1:0] S_PAD  = 2'd1;  // feed padding bytes
  localparam logic [1:0] S_CMP  = 2'd2;  // wait for the compression unit
  localparam logic [1:0] S_OUT  = 2'd3;  // hand out the digest words

  // Padding phases
  localparam logic [1:0] PAD_MARK = 2'd0;
  localparam logic [1:0] PAD_ZERO = 2'd1;
  localparam logic [1:0] PAD_LEN  = 2'd2;

  logic [1:0]  state;
  logic [5:0]  fill;       // bytes held in the current block
  logic [23:0] acc;        // first three bytes of the message word being assembled
  logic [60:0] count;      // message bytes so far; the bit length wraps at 2^64 anyway
  logic [1:0]  pad_stage;
  logic [2:0]  len_idx;
  logic        padding;
  logic        pad_done;
  logic [1:0]  out_idx;
  logic        out_valid;

  logic        accept;
  logic        absorb;
  logic [7:0]  abyte;
  logic [63:0] bits;
  logic        cmp_done;
  logic [3:0][31:0] cv;
  md5_ctl_t    ctl;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign bits          = {count, 3'b000};

  // Pick the byte that enters the block this cycle, from the request or the padding
  always_comb begin
    absorb = 1'b0;
    abyte  = s_axis_tdata;
    case (state)
      S_IDLE: absorb = accept && s_axis_tuser;
      S_PAD: begin
        case (pad_stage)
          PAD_MARK: begin
            absorb = 1'b1;
            abyte  = MD5_PAD_MARK;
          end
          PAD_ZERO: begin
            absorb = (fill != MD5_LEN_POS);
            abyte  = '0;
          end
          PAD_LEN: begin
            absorb = 1'b1;
            abyte  = bits[{len_idx, 3'b000} +: 8];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Write a whole word once its fourth byte arrives; start compression on the last one
  always_comb begin
    ctl.wr_en   = absorb && (fill[1:0] == 2'd3);
    ctl.wr_addr = fill[5:2];
    ctl.start   = absorb && (fill == 6'd63);
    ctl.restart = (state == S_OUT) && m_axis_tready && (out_idx == 2'd3);
  end

  md5_cmp u_cmp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_data ({abyte, acc}),
    .done    (cmp_done),
    .cv      (cv)
  );

  // Shift bytes in from the top so the first byte lands lowest
  always_ff @(posedge clk) begin
    if (absorb) begin
      acc <= {abyte, acc[23:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      count     <= '0;
      pad_stage <= PAD_MARK;
      len_idx   <= '0;
      padding   <= 1'b0;
      pad_done  <= 1'b0;
      out_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (absorb) begin
        fill <= 6'(fill + 6'd1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              count <= count + 61'd1;
            end
            if (s_axis_tlast) begin
              padding   <= 1'b1;
              pad_stage <= PAD_MARK;
            end
            // a full block goes first; padding resumes after it
            if (ctl.start) begin
              state <= S_CMP;
            end else if (s_axis_tlast) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          case (pad_stage)
            PAD_MARK: pad_stage <= PAD_ZERO;
            PAD_ZERO: begin
              if (fill == MD5_LEN_POS) begin
                pad_stage <= PAD_LEN;
                len_idx   <= '0;
              end
            end
            PAD_LEN: begin
              len_idx <= 3'(len_idx + 3'd1);
              if (len_idx == 3'd7) begin
                pad_done <= 1'b1;
              end
            end
            default: pad_stage <= PAD_MARK;
          endcase
          if (ctl.start) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp_done) begin
            if (pad_done) begin
              state     <= S_OUT;
              out_valid <= 1'b1;
              out_idx   <= '0;
            end else if (padding) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            out_idx <= 2'(out_idx + 2'd1);
            // drop back to the initial state after the fourth word
            if (out_idx == 2'd3) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
              fill      <= '0;
              count     <= '0;
              padding   <= 1'b0;
              pad_done  <= 1'b0;
              pad_stage <= PAD_MARK;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Chaining words hold still while the digest is handed out
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = cv[out_idx];
  assign m_axis_tuser  = out_idx;
  assign m_axis_tlast  = (out_idx == 2'd3);

endmodule

// File: tb/tb_md5_message_digest.sv
`timescale 1ns / 1ps

module tb_md5_message_digest;

  // One digest result: word, its index and the final-word flag
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        fin;
  } digest_word_t;

  // One row of the directed table; want is used only where known is set
  typedef struct packed {
    logic [7:0]        data;
    logic              byte_ok;
    logic              ends;
    logic              known;
    logic [0:3][31:0]  want;
  } stim_row_t;

  localparam logic [0:3][31:0] CHAIN_START = {
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [0:63][31:0] ROUND_ADD = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts by {round group, round mod 4}
  localparam logic [0:15][4:0] ROUND_ROT = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Well-known digests, as little-endian words
  localparam logic [0:3][31:0] EMPTY_DIGEST = {
    32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec
  };
  localparam logic [0:3][31:0] A_DIGEST = {
    32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769
  };
  localparam logic [0:3][31:0] ABC_DIGEST = {
    32'h98500190, 32'hb04fd23c, 32'h7d3f96d6, 32'h727fe128
  };

  // Message lengths around the padding boundaries: one or two extra blocks
  localparam logic [0:9][7:0] EDGE_LEN = {
    8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65, 8'd119, 8'd120, 8'd127, 8'd128
  };

  localparam int RANDOM_REQUESTS = 400;
  localparam int CALM_FROM       = 340;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] byte_valid
  logic        s_axis_tlast;   // last_item
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] digest_word
  logic [1:0]  m_axis_tuser;   // [1:0] word_index
  logic        m_axis_tlast;   // last_word

  md5_message_digest dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Hashing state held alongside the block
  logic [31:0]  chain_words [4];
  logic [31:0]  block_words [16];
  logic [6:0]   fill;
  logic [63:0]  message_bytes;

  digest_word_t digest_expected [$];
  stim_row_t    directed [$];
  int           mismatch_count;
  bit           calm_tail;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("md5_message_digest: mismatch");
    $finish;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - n));
  endfunction

  task automatic md5_restart();
    for (int i = 0; i < 4; i++) chain_words[i] = CHAIN_START[i];
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    fill = '0;
    message_bytes = '0;
  endtask

  task automatic md5_compress_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + ROUND_ADD[r] + block_words[g], ROUND_ROT[(r / 16) * 4 + r % 4]);
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
  endtask

  // Pack little-endian; clear a word when its first lane arrives
  task automatic md5_absorb_byte(input logic [7:0] b);
    logic [5:0] pos;
    pos = fill[5:0];
    if (pos[1:0] == 2'd0) begin
      block_words[pos[5:2]] = {24'd0, b};
    end else begin
      block_words[pos[5:2]] = block_words[pos[5:2]] | ({24'd0, b} << (8 * pos[1:0]));
    end
    if (pos == 6'd63) begin
      md5_compress_block();
      fill = '0;
    end else begin
      fill = {1'b0, pos} + 7'd1;
    end
  endtask

  // Advance the hash by one accepted request; queue the digest on a last request
  task automatic md5_take_request(input logic [7:0] d, input logic v, input logic e,
                                  input logic use_typed, input logic [0:3][31:0] typed);
    logic [63:0]  bit_len;
    digest_word_t w;
    if (v) begin
      md5_absorb_byte(d);
      message_bytes = message_bytes + 64'd1;
    end
    if (e) begin
      bit_len = message_bytes << 3;
      md5_absorb_byte(8'h80);
      while (fill != 7'd56) md5_absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) md5_absorb_byte(bit_len[8 * i +: 8]);
      for (int i = 0; i < 4; i++) begin
        w.word = use_typed ? typed[i] : chain_words[i];
        w.idx  = 2'(i);
        w.fin  = (i == 3);
        digest_expected.push_back(w);
      end
      md5_restart();
    end
  endtask

  // Offer one request, with an occasional gap first, and hold it until taken
  task automatic send_request(input logic [7:0] d, input logic v, input logic e);
    int unsigned gap;
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= v;
    s_axis_tlast  <= e;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic add_row(input logic [7:0] d, input logic v, input logic e,
                         input logic k, input logic [0:3][31:0] w);
    stim_row_t row;
    row.data    = d;
    row.byte_ok = v;
    row.ends    = e;
    row.known   = k;
    row.want    = w;
    directed.push_back(row);
  endtask

  task automatic report_mismatch(input string why, input digest_word_t want,
                                 input digest_word_t got);
    if (mismatch_count < 10) begin
      $display("%0t %s: expected word %h idx %0d fin %b, got word %h idx %0d fin %b",
               $realtime, why, want.word, want.idx, want.fin, got.word, got.idx, got.fin);
    end
    mismatch_count++;
  endtask

  // Result side: check each taken word against the oldest expectation, stall in bursts
  initial begin : digest_sink
    int unsigned  hold;
    digest_word_t got;
    digest_word_t want;
    hold = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.word = m_axis_tdata;
        got.idx  = m_axis_tuser;
        got.fin  = m_axis_tlast;
        if (digest_expected.size() == 0) begin
          report_mismatch("unexpected digest word", '0, got);
        end else begin
          want = digest_expected.pop_front();
          if (got.word !== want.word || got.idx !== want.idx || got.fin !== want.fin) begin
            report_mismatch("digest word differs", want, got);
          end
        end
      end
      if (calm_tail) begin
        hold = 0;
        m_axis_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Request side: reset, directed table, then random messages
  initial begin : message_source
    int          sent;
    int unsigned len;
    bit          tail;
    logic [7:0]  b;
    stim_row_t   row;

    mismatch_count = 0;
    calm_tail      = 1'b0;
    md5_restart();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Idle requests, empty messages, a single byte, "abc", byte extremes and
    // ignored bytes on both idle and last requests
    add_row(8'hff, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'ha5, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);
    add_row(8'h61, 1'b1, 1'b1, 1'b1, A_DIGEST);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST);
    add_row(8'hff, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h7f, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'haa, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST);

    foreach (directed[i]) begin
      row = directed[i];
      send_request(row.data, row.byte_ok, row.ends);
      md5_take_request(row.data, row.byte_ok, row.ends, row.known, row.want);
    end

    // Mostly short messages, a quarter at lengths that straddle the padding edge;
    // the last byte rides on the last request about half the time
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 3) == 0) len = 32'(EDGE_LEN[$urandom_range(0, 9)]);
      else len = $urandom_range(0, 16);
      tail = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          b = 8'($urandom);
          send_request(b, 1'b0, 1'b0);
          md5_take_request(b, 1'b0, 1'b0, 1'b0, '0);
          sent++;
          calm_tail = (sent >= CALM_FROM);
        end
        b = 8'($urandom);
        send_request(b, 1'b1, tail && (i == len - 1));
        md5_take_request(b, 1'b1, tail && (i == len - 1), 1'b0, '0);
        sent++;
        calm_tail = (sent >= CALM_FROM);
      end
      if (!tail) begin
        b = 8'($urandom);
        send_request(b, 1'b0, 1'b1);
        md5_take_request(b, 1'b0, 1'b1, 1'b0, '0);
        sent++;
        calm_tail = (sent >= CALM_FROM);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding digests, then allow for any stray words
    while (digest_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("md5_message_digest: match");
    end else begin
      $display("md5_message_digest: mismatch");
    end
    $finish;
  end

endmodule
